FILE: src/blsc_pkg.sv
// Shared types and constants for the bullet line scanner.
`timescale 1ns / 1ps

package blsc_pkg;

   // Object RAM geometry
   localparam int RAM_DEPTH  = 256;
   localparam int ADDR_W     = 8;
   localparam int DATA_W     = 8;

   // Bullet table layout
   localparam int BULLET_COUNT = 8;
   localparam int IDX_W        = (BULLET_COUNT > 1) ? $clog2(BULLET_COUNT) : 1;
   localparam int BULLET_BASE  = 'h60;
   localparam int BULLET_LAST  = BULLET_COUNT - 1;
   localparam int FIRST_LATE   = 3;

   // Hit test and span start
   localparam logic [DATA_W-1:0] HIT_SUM    = 8'hFF;
   localparam logic [DATA_W-1:0] EARLY_OFS  = 8'd15;
   localparam logic [DATA_W-1:0] LATE_OFS   = 8'd16;
   localparam int                START_W    = 9;
   localparam logic signed [START_W-1:0] START_BASE = 9'sd251;

   // Command codes
   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_SCAN  = 2'd2
   } blsc_cmd_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_RDWAIT,
      ST_SCAN,
      ST_XSHELL,
      ST_XMISSILE,
      ST_DONE
   } blsc_state_type;

   // Request to the object RAM
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } blsc_ram_req_type;

endpackage

FILE: src/blsc_ram.sv
// Object RAM: 256 x 8, one write and one registered read per cycle.
`timescale 1ns / 1ps

module blsc_ram
   import blsc_pkg::*;
(
   input  logic              clock,
   input  blsc_ram_req_type  ram_req,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [RAM_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[ram_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/bullet_line_scanner_core.sv
// Top level of the bullet line scanner: command sequencer around the object RAM.
`timescale 1ns / 1ps

// Bullet line scanner. Each request item carries a command in req_tuser: write one
// object RAM byte, read one byte, or scan one line against the bullet table at 0x60.
// Every request returns exactly one response item. In a scan the single RAM read
// port fetches one position byte per cycle, then the x bytes of the winning shell
// and of the missile. After reset the RAM is cleared to zero one byte per cycle,
// so no request is taken until the clear is done. A finished response waits in an
// output register and one further request may be worked on meanwhile.
module bullet_line_scanner_core
   import blsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // addr[7:0], wdata[15:8], line[23:16]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // rdata[7:0], shell_start[16:8],
                                    // missile_start[25:17], zero[31:26]
   output logic [1:0]  rsp_tuser    // shell_hit[0], missile_hit[1]
);

   blsc_state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   blsc_cmd_type      cmd_ff, cmd_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [DATA_W-1:0] wdata_ff, wdata_in;
   logic [DATA_W-1:0] line_ff, line_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;
   logic              shell_hit_ff, shell_hit_in;
   logic [IDX_W-1:0]  shell_idx_ff, shell_idx_in;
   logic              missile_hit_ff, missile_hit_in;
   logic signed [START_W-1:0] shell_start_ff, shell_start_in;
   logic signed [START_W-1:0] missile_start_ff, missile_start_in;
   logic [DATA_W-1:0] rdata_ff, rdata_in;

   logic              rsp_vld_ff, rsp_vld_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;
   logic [1:0]        rsp_user_ff, rsp_user_in;

   blsc_ram_req_type  ram_req;
   logic [DATA_W-1:0] rd_data;
   logic              req_take;
   logic              rsp_load;
   logic              late;
   logic [DATA_W-1:0] eff_line;
   logic              hit_now;
   logic signed [START_W-1:0] start_now;

   blsc_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // Hit test on the position byte fetched last cycle
   always_comb begin
      late      = (int'(chk_idx_ff) >= FIRST_LATE) || (int'(chk_idx_ff) == BULLET_LAST);
      eff_line  = line_ff + (late ? LATE_OFS : EARLY_OFS);
      hit_now   = chk_vld_ff && ((rd_data + eff_line) == HIT_SUM);
      start_now = START_BASE - $signed({1'b0, rd_data});
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;

   // Sequencer: next state, RAM requests and result fields
   always_comb begin
      state_in         = state_ff;
      clr_in           = clr_ff;
      idx_in           = idx_ff;
      cmd_in           = cmd_ff;
      addr_in          = addr_ff;
      wdata_in         = wdata_ff;
      line_in          = line_ff;
      chk_vld_in       = 1'b0;
      chk_idx_in       = chk_idx_ff;
      shell_hit_in     = shell_hit_ff;
      shell_idx_in     = shell_idx_ff;
      missile_hit_in   = missile_hit_ff;
      shell_start_in   = shell_start_ff;
      missile_start_in = missile_start_ff;
      rdata_in         = rdata_ff;
      rsp_load         = 1'b0;
      ram_req.wr_en    = 1'b0;
      ram_req.wr_addr  = addr_ff;
      ram_req.wr_data  = wdata_ff;
      ram_req.rd_addr  = addr_ff;

      // Fold in a hit from the previous position fetch
      if (hit_now) begin
         if (int'(chk_idx_ff) == BULLET_LAST) begin
            missile_hit_in = 1'b1;
         end else begin
            shell_hit_in = 1'b1;
            shell_idx_in = chk_idx_ff;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = clr_ff;
            ram_req.wr_data = '0;
            clr_in          = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(RAM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               cmd_in           = blsc_cmd_type'(req_tuser);
               addr_in          = req_tdata[7:0];
               wdata_in         = req_tdata[15:8];
               line_in          = req_tdata[23:16];
               shell_hit_in     = 1'b0;
               shell_idx_in     = '0;
               missile_hit_in   = 1'b0;
               shell_start_in   = '0;
               missile_start_in = '0;
               rdata_in         = '0;
               state_in         = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (cmd_ff)
               CMD_WRITE: begin
                  ram_req.wr_en = 1'b1;
                  state_in      = ST_DONE;
               end
               CMD_READ: begin
                  state_in = ST_RDWAIT;
               end
               CMD_SCAN: begin
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_RDWAIT: begin
            rdata_in = rd_data;
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            // Fetch the position byte of one entry per cycle
            ram_req.rd_addr = ADDR_W'(BULLET_BASE + 4 * int'(idx_ff) + 1);
            chk_vld_in      = 1'b1;
            chk_idx_in      = idx_ff;
            idx_in          = idx_ff + 1'b1;
            if (int'(idx_ff) == BULLET_LAST) begin
               state_in = ST_XSHELL;
            end
         end
         ST_XSHELL: begin
            // Last fetch was the missile, so the shell winner is settled
            ram_req.rd_addr = ADDR_W'(BULLET_BASE + 4 * int'(shell_idx_ff) + 3);
            state_in        = ST_XMISSILE;
         end
         ST_XMISSILE: begin
            if (shell_hit_ff) begin
               shell_start_in = start_now;
            end
            ram_req.rd_addr = ADDR_W'(BULLET_BASE + 4 * BULLET_LAST + 3);
            idx_in          = '0;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Missile x byte arrives the cycle after its fetch
   logic xm_pend_ff;
   logic signed [START_W-1:0] missile_start_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         xm_pend_ff <= 1'b0;
      end else begin
         xm_pend_ff <= (state_ff == ST_XMISSILE);
      end
   end

   always_comb begin
      missile_start_q = missile_start_ff;
      if (xm_pend_ff && missile_hit_ff) begin
         missile_start_q = start_now;
      end
   end

   // Output register feeds
   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = {6'd0, missile_start_q, shell_start_ff, rdata_ff};
         rsp_user_in = {missile_hit_ff, shell_hit_ff};
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         chk_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         chk_vld_ff <= chk_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff           <= idx_in;
      cmd_ff           <= cmd_in;
      addr_ff          <= addr_in;
      wdata_ff         <= wdata_in;
      line_ff          <= line_in;
      chk_idx_ff       <= chk_idx_in;
      shell_hit_ff     <= shell_hit_in;
      shell_idx_ff     <= shell_idx_in;
      missile_hit_ff   <= missile_hit_in;
      shell_start_ff   <= shell_start_in;
      missile_start_ff <= xm_pend_ff ? missile_start_q : missile_start_in;
      rdata_ff         <= rdata_in;
      rsp_data_ff      <= rsp_data_in;
      rsp_user_ff      <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the bullet line scanner core.
`timescale 1ns / 1ps

module testbench;
   import blsc_pkg::*;

   // Unused command code: must leave the RAM alone and return all zeros
   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam int RANDOM_ITEMS = 1150;
   localparam int IDLE_PCT     = 38;
   localparam int QUIET_FIRST  = 600;
   localparam int QUIET_LAST   = 780;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] addr;
      logic [7:0] wdata;
      logic [7:0] line;
   } bus_cmd_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic       shell_hit;
      logic [8:0] shell_start;
      logic       missile_hit;
      logic [8:0] missile_start;
   } scan_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // addr[7:0], wdata[15:8], line[23:16]
   logic [1:0]  req_tuser = '0;   // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // rdata[7:0], shell_start[16:8],
                                  // missile_start[25:17], zero[31:26]
   logic [1:0]  rsp_tuser;        // shell_hit[0], missile_hit[1]

   bus_cmd_type  bus_cmds[$];
   scan_rsp_type due_rsps[$];
   bus_cmd_type  cur_cmd;
   logic [7:0] shadow_ram [RAM_DEPTH];
   int        cmds_total = 0;
   int        cmds_taken = 0;
   int        rsps_seen = 0;
   int        errors = 0;

   bullet_line_scanner_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // Position byte offset used by a bullet entry when testing a line
   function automatic logic [7:0] line_offset(input int entry);
      if (entry >= FIRST_LATE || entry == BULLET_LAST) begin
         return LATE_OFS;
      end
      return EARLY_OFS;
   endfunction

   function automatic logic [8:0] span_start(input int entry);
      logic [7:0] x;
      x = shadow_ram[8'(BULLET_BASE + entry * 4 + 3)];
      return 9'(START_BASE) - {1'b0, x};
   endfunction

   function automatic logic entry_on_line(input int entry, input logic [7:0] line);
      logic [7:0] pos;
      logic [7:0] sum;
      pos = shadow_ram[8'(BULLET_BASE + entry * 4 + 1)];
      sum = pos + line + line_offset(entry);
      return sum == HIT_SUM;
   endfunction

   // Apply one command to the shadow RAM and return the response it causes
   function automatic scan_rsp_type apply_bus_cmd(input bus_cmd_type c);
      scan_rsp_type r;
      r = '0;
      case (c.cmd)
         CMD_WRITE: shadow_ram[c.addr] = c.wdata;
         CMD_READ:  r.rdata = shadow_ram[c.addr];
         CMD_SCAN: begin
            // Highest shell index that hits wins
            for (int e = 0; e < BULLET_LAST; e++) begin
               if (entry_on_line(e, c.line)) begin
                  r.shell_hit   = 1'b1;
                  r.shell_start = span_start(e);
               end
            end
            if (entry_on_line(BULLET_LAST, c.line)) begin
               r.missile_hit   = 1'b1;
               r.missile_start = span_start(BULLET_LAST);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic add_cmd(input logic [1:0] cmd, input logic [7:0] addr,
                          input logic [7:0] wdata, input logic [7:0] line);
      bus_cmd_type c;
      c.cmd   = cmd;
      c.addr  = addr;
      c.wdata = wdata;
      c.line  = line;
      bus_cmds.push_back(c);
      cmds_total++;
   endtask

   // Drive request items from the pending queue, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            due_rsps.push_back(apply_bus_cmd(cur_cmd));
            cmds_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (bus_cmds.size() != 0 &&
                ((cmds_taken >= QUIET_FIRST && cmds_taken < QUIET_LAST) ||
                 $urandom_range(99) >= IDLE_PCT)) begin
               cur_cmd = bus_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {cur_cmd.line, cur_cmd.wdata, cur_cmd.addr};
               req_tuser  <= cur_cmd.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Check each response item against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsps_seen++;
            if (due_rsps.size() == 0) begin
               $error("response item with no prediction waiting");
               errors++;
            end else begin
               scan_rsp_type want;
               want = due_rsps.pop_front();
               if (rsp_tdata[7:0] !== want.rdata) begin
                  $error("rdata: expected %0h, got %0h", want.rdata, rsp_tdata[7:0]);
                  errors++;
               end
               if (rsp_tuser[0] !== want.shell_hit) begin
                  $error("shell_hit: expected %0b, got %0b", want.shell_hit, rsp_tuser[0]);
                  errors++;
               end
               if (rsp_tdata[16:8] !== want.shell_start) begin
                  $error("shell_start: expected %0d, got %0d",
                         $signed(want.shell_start), $signed(rsp_tdata[16:8]));
                  errors++;
               end
               if (rsp_tuser[1] !== want.missile_hit) begin
                  $error("missile_hit: expected %0b, got %0b",
                         want.missile_hit, rsp_tuser[1]);
                  errors++;
               end
               if (rsp_tdata[25:17] !== want.missile_start) begin
                  $error("missile_start: expected %0d, got %0d",
                         $signed(want.missile_start), $signed(rsp_tdata[25:17]));
                  errors++;
               end
               if (rsp_tdata[31:26] !== 6'd0) begin
                  $error("zero: expected 0, got %0h", rsp_tdata[31:26]);
                  errors++;
               end
            end
         end
         rsp_tready <= (rsps_seen >= QUIET_FIRST && rsps_seen < QUIET_LAST) ||
                       ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Stimulus, then drain and final verdict
   initial begin
      logic [7:0] hot_line;
      int         pick;
      int         entry;
      logic [7:0] a;
      logic [7:0] d;

      foreach (shadow_ram[k]) shadow_ram[k] = '0;

      // Directed: shells and missile on line 100, priority, extremes of x
      add_cmd(CMD_WRITE, 8'h61, 8'd140, 8'h00);   // entry 0 position
      add_cmd(CMD_WRITE, 8'h63, 8'd0,   8'hFF);   // entry 0 x, start 251
      add_cmd(CMD_SCAN,  8'h00, 8'h00,  8'd100);
      add_cmd(CMD_WRITE, 8'h6D, 8'd139, 8'h00);   // entry 3 position
      add_cmd(CMD_WRITE, 8'h6F, 8'd255, 8'h00);   // entry 3 x, start -4
      add_cmd(CMD_WRITE, 8'h7D, 8'd139, 8'h00);   // missile position
      add_cmd(CMD_WRITE, 8'h7F, 8'd251, 8'h00);   // missile x, start 0
      add_cmd(CMD_SCAN,  8'hFF, 8'hFF,  8'd100);
      add_cmd(CMD_WRITE, 8'h79, 8'd139, 8'h00);   // entry 6 position
      add_cmd(CMD_WRITE, 8'h7B, 8'd128, 8'h00);
      add_cmd(CMD_SCAN,  8'h00, 8'h00,  8'd100);
      add_cmd(CMD_READ,  8'h7B, 8'hFF,  8'hFF);
      add_cmd(CMD_READ,  8'h00, 8'h00,  8'h00);
      add_cmd(CMD_WRITE, 8'hFF, 8'hFF,  8'hFF);
      add_cmd(CMD_READ,  8'hFF, 8'h00,  8'h00);
      // Unused command with busy fields leaves everything unchanged
      add_cmd(CMD_NONE,  8'h61, 8'hAA,  8'hFF);
      add_cmd(CMD_READ,  8'h61, 8'h00,  8'h00);
      // Line past the visible range wraps the offset sum
      add_cmd(CMD_WRITE, 8'h65, 8'd241, 8'h00);   // entry 1 position for line 255
      add_cmd(CMD_SCAN,  8'h00, 8'h00,  8'd255);
      add_cmd(CMD_SCAN,  8'h00, 8'h00,  8'd0);
      add_cmd(CMD_SCAN,  8'h00, 8'h00,  8'd223);
      add_cmd(CMD_WRITE, 8'h00, 8'h00,  8'h00);

      // Random: writes, many aimed at a moving hot line, mixed with scans mostly of it
      hot_line = 8'($urandom_range(223));
      repeat (RANDOM_ITEMS) begin
         if ($urandom_range(9) == 0) begin
            hot_line = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 224))
                                                : 8'($urandom_range(223));
         end
         pick  = $urandom_range(99);
         entry = $urandom_range(BULLET_COUNT - 1);
         a     = 8'($urandom);
         d     = 8'($urandom);
         if (pick < 40) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               a = 8'(BULLET_BASE + entry * 4 + 1);
               if ($urandom_range(9) < 7) d = HIT_SUM - hot_line - line_offset(entry);
            end else if (pick < 70) begin
               a = 8'(BULLET_BASE + entry * 4 + 3);
               if ($urandom_range(4) == 0) d = 8'($urandom_range(255, 248));
            end
            add_cmd(CMD_WRITE, a, d, 8'($urandom));
         end else if (pick < 55) begin
            if ($urandom_range(1) == 0) a = 8'(BULLET_BASE + $urandom_range(31));
            add_cmd(CMD_READ, a, d, 8'($urandom));
         end else if (pick < 95) begin
            add_cmd(CMD_SCAN, a, d,
                    ($urandom_range(4) != 0) ? hot_line : 8'($urandom));
         end else begin
            add_cmd(CMD_NONE, a, d, 8'($urandom));
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wait for all items to go in and all responses to come back
      while (cmds_taken != cmds_total || due_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (due_rsps.size() != 0) begin
         $error("%0d predicted responses never arrived", due_rsps.size());
         errors++;
      end
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Hard stop if the block hangs
   initial begin
      #10ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
